// ===== hdl/checkerboard_tiling_automaton_top_macros.svh =====
// Assertion macros shared by the checker of the tiling automaton.
`ifndef CHECKERBOARD_TILING_AUTOMATON_TOP_MACROS_SVH
`define CHECKERBOARD_TILING_AUTOMATON_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define CTA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define CTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbta_pkg.sv =====
// Types, codes and the neighbor rule of the checkerboard tiling automaton.
package cbta_pkg;

    localparam int CELL_W = 3;

    localparam logic [CELL_W-1:0] CODE_EMPTY = 3'd0;
    localparam logic [CELL_W-1:0] CODE_VERT  = 3'd1;
    localparam logic [CELL_W-1:0] CODE_HORZ  = 3'd2;
    localparam logic [CELL_W-1:0] CODE_DOWN  = 3'd3;
    localparam logic [CELL_W-1:0] CODE_LEFT  = 3'd4;
    localparam logic [CELL_W-1:0] CODE_UP    = 3'd5;
    localparam logic [CELL_W-1:0] CODE_RIGHT = 3'd6;

    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;
    localparam logic [31:0] LFSR_ONE  = 32'd1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_STALE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] row;
        logic [6:0] col;
    } cbta_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_code;
        logic [15:0]       generation;
    } cbta_out_t;

    typedef enum logic [3:0] {
        ST_CLR_START,
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_STALE,
        ST_ADV_A,
        ST_ADV_B,
        ST_ADV_FLUSH,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic iter_start;
        logic iter_stride2;
        logic iter_step;
        logic sweep_wr;
        logic sweep_ctr;
        logic init_load;
        logic gen_inc;
        logic adv_rd_vert;
        logic adv_rd_horz;
        logic adv_wr;
        logic rd_addr;
        logic rd_mem;
        logic load_result;
    } cbta_cmd_t;

    typedef struct packed {
        logic iter_last;
    } cbta_status_t;

    typedef struct packed {
        logic              need_rand;
        logic [CELL_W-1:0] code;
    } cbta_rule_t;

    // Next value of a recomputed cell from its four (masked) neighbors.
    function automatic cbta_rule_t cbta_rule(input logic [CELL_W-1:0] up,
                                             input logic [CELL_W-1:0] rt,
                                             input logic [CELL_W-1:0] dn,
                                             input logic [CELL_W-1:0] lf);
        logic [3:0] hit;
        logic       any_set;
        cbta_rule_t r;
        hit[0]  = (up == CODE_DOWN)  || (up == CODE_VERT);
        hit[1]  = (rt == CODE_LEFT)  || (rt == CODE_HORZ);
        hit[2]  = (dn == CODE_UP)    || (dn == CODE_VERT);
        hit[3]  = (lf == CODE_RIGHT) || (lf == CODE_HORZ);
        any_set = (up != CODE_EMPTY) || (rt != CODE_EMPTY) ||
                  (dn != CODE_EMPTY) || (lf != CODE_EMPTY);
        r.code = CODE_EMPTY;
        if (hit[0]) r.code = CODE_DOWN;
        if (hit[1]) r.code = CODE_LEFT;
        if (hit[2]) r.code = CODE_UP;
        if (hit[3]) r.code = CODE_RIGHT;
        r.need_rand = ((hit & (hit - 4'd1)) != 4'd0) || ((hit == 4'd0) && any_set);
        return r;
    endfunction

endpackage

// ===== hdl/cbta_ctrl.sv =====
// Sequencer of the tiling automaton: sweeps, advance pipeline, reads and result handoff.
module cbta_ctrl import cbta_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  op_t          s_op,
    input  logic         m_ready,
    input  cbta_status_t status,
    output logic         s_ready,
    output logic         m_valid,
    output cbta_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR_START: state_next = ST_CLEAR;
            ST_CLEAR:     if (status.iter_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        OP_INIT:    state_next = ST_INIT;
                        OP_ADVANCE: state_next = ST_ADV_A;
                        OP_READ:    state_next = ST_RD_ADDR;
                        OP_STALE:   state_next = ST_STALE;
                    endcase
                end
            end
            ST_INIT:      if (status.iter_last) state_next = ST_RESP;
            ST_STALE:     if (status.iter_last) state_next = ST_RESP;
            ST_ADV_A:     state_next = ST_ADV_B;
            ST_ADV_B:     state_next = status.iter_last ? ST_ADV_FLUSH : ST_ADV_A;
            ST_ADV_FLUSH: state_next = ST_RESP;
            ST_RD_ADDR:   state_next = ST_RD_MEM;
            ST_RD_MEM:    state_next = ST_RESP;
            ST_RESP:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_CLR_START;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLR_START: cmd.iter_start = 1'b1;
            ST_CLEAR: begin
                cmd.sweep_wr  = 1'b1;
                cmd.iter_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    unique case (s_op)
                        OP_INIT: begin
                            cmd.iter_start = 1'b1;
                            cmd.init_load  = 1'b1;
                        end
                        OP_ADVANCE: begin
                            cmd.iter_start   = 1'b1;
                            cmd.iter_stride2 = 1'b1;
                            cmd.gen_inc      = 1'b1;
                        end
                        OP_READ: ;
                        OP_STALE: begin
                            cmd.iter_start   = 1'b1;
                            cmd.iter_stride2 = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                cmd.sweep_wr  = 1'b1;
                cmd.sweep_ctr = 1'b1;
                cmd.iter_step = 1'b1;
            end
            ST_STALE: begin
                cmd.sweep_wr  = 1'b1;
                cmd.iter_step = 1'b1;
            end
            ST_ADV_A: begin
                cmd.adv_rd_vert = 1'b1;
                cmd.adv_wr      = 1'b1;
            end
            ST_ADV_B: begin
                cmd.adv_rd_horz = 1'b1;
                cmd.iter_step   = 1'b1;
            end
            ST_ADV_FLUSH: cmd.adv_wr = 1'b1;
            ST_RD_ADDR:   cmd.rd_addr = 1'b1;
            ST_RD_MEM:    cmd.rd_mem = 1'b1;
            ST_RESP:      cmd.load_result = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR_START;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/cbta_dpath.sv =====
// Datapath of the tiling automaton: cell memory, cell walker, neighbor rule, LFSR, result.
module cbta_dpath import cbta_pkg::*; #(
    parameter int GRID_SIZE = 81
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cbta_cmd_t    cmd,
    input  cbta_in_t     s_data,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data,
    output cbta_status_t status,
    output cbta_out_t    m_data
);

    localparam int CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(GRID_SIZE);
    localparam logic [ADDR_W-1:0] CENTER_ADDR =
        ADDR_W'((GRID_SIZE / 2) * GRID_SIZE + GRID_SIZE / 2);
    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(GRID_SIZE - 1);
    localparam logic [IDX_W:0]    ROW_LEN     = (IDX_W + 1)'(GRID_SIZE);

    logic [CELL_W-1:0] mem [CELLS];

    logic [31:0]       seed_reg, lfsr_reg;
    logic [15:0]       gen_reg;
    op_t               op_reg;
    logic [6:0]        row_in_reg, col_in_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_inrange_reg;

    logic [IDX_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, base_reg, base_next;
    logic              phase_reg, phase_next, stride2_reg, stride2_next;

    logic [CELL_W-1:0] rdata0_reg, rdata1_reg, up_reg, dn_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_lok_reg, pend_rok_reg, pend_valid_reg;
    cbta_out_t         out_reg;

    // Walker over the grid in raster order, every cell or every other cell.
    logic [IDX_W:0]    col_adv;
    logic              row_end, start_phase;
    logic [IDX_W-1:0]  row_first_col;
    logic [ADDR_W-1:0] step_addr;

    assign col_adv       = {1'b0, col_reg} + (stride2_reg ? (IDX_W + 1)'(2) : (IDX_W + 1)'(1));
    assign row_end       = col_adv >= ROW_LEN;
    assign row_first_col = IDX_W'(stride2_reg & ~phase_reg);
    assign step_addr     = stride2_reg ? ADDR_W'(2) : ADDR_W'(1);
    assign start_phase   = cmd.iter_stride2 & ~gen_reg[0];
    assign status.iter_last = (row_reg == LAST_IDX) && row_end;

    always_comb begin
        row_next     = row_reg;
        col_next     = col_reg;
        addr_next    = addr_reg;
        base_next    = base_reg;
        phase_next   = phase_reg;
        stride2_next = stride2_reg;
        if (cmd.iter_start) begin
            row_next     = '0;
            col_next     = IDX_W'(start_phase);
            addr_next    = ADDR_W'(start_phase);
            base_next    = '0;
            phase_next   = start_phase;
            stride2_next = cmd.iter_stride2;
        end else if (cmd.iter_step) begin
            if (row_end) begin
                row_next   = row_reg + IDX_W'(1);
                col_next   = row_first_col;
                base_next  = base_reg + ROW_STEP;
                addr_next  = base_reg + ROW_STEP + ADDR_W'(row_first_col);
                phase_next = ~phase_reg;
            end else begin
                col_next  = col_adv[IDX_W-1:0];
                addr_next = addr_reg + step_addr;
            end
        end
    end

    // Neighbor addresses; an off-grid neighbor reads the cell itself and is masked.
    logic              up_ok, dn_ok, lf_ok, rt_ok;
    logic [ADDR_W-1:0] rd0_addr, rd1_addr;
    logic              rd_en;

    assign up_ok = row_reg != '0;
    assign dn_ok = row_reg != LAST_IDX;
    assign lf_ok = col_reg != '0;
    assign rt_ok = col_reg != LAST_IDX;
    assign rd_en = cmd.adv_rd_vert || cmd.adv_rd_horz || cmd.rd_mem;

    always_comb begin
        if (cmd.adv_rd_vert) begin
            rd0_addr = up_ok ? addr_reg - ROW_STEP : addr_reg;
            rd1_addr = dn_ok ? addr_reg + ROW_STEP : addr_reg;
        end else if (cmd.adv_rd_horz) begin
            rd0_addr = lf_ok ? addr_reg - ADDR_W'(1) : addr_reg;
            rd1_addr = rt_ok ? addr_reg + ADDR_W'(1) : addr_reg;
        end else begin
            rd0_addr = rd_addr_reg;
            rd1_addr = rd_addr_reg;
        end
    end

    // Rule for the pending cell; its horizontal neighbors sit in the read registers.
    logic [CELL_W-1:0] lf_val, rt_val, new_code, wr_data;
    cbta_rule_t        rule;
    logic              adv_we, we;
    logic [ADDR_W-1:0] wr_addr;

    assign lf_val   = pend_lok_reg ? rdata0_reg : CODE_EMPTY;
    assign rt_val   = pend_rok_reg ? rdata1_reg : CODE_EMPTY;
    assign rule     = cbta_rule(up_reg, rt_val, dn_reg, lf_val);
    assign new_code = rule.need_rand ? (lfsr_reg[0] ? CODE_HORZ : CODE_VERT) : rule.code;
    assign adv_we   = cmd.adv_wr && pend_valid_reg;
    assign we       = cmd.sweep_wr || adv_we;
    assign wr_addr  = cmd.sweep_wr ? addr_reg : pend_addr_reg;
    assign wr_data  = cmd.sweep_wr ?
                      ((cmd.sweep_ctr && (addr_reg == CENTER_ADDR)) ? CODE_VERT : CODE_EMPTY) :
                      new_code;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata0_reg <= mem[rd0_addr];
            rdata1_reg <= mem[rd1_addr];
        end
    end

    // Address of a requested cell.
    logic        rd_inrange;
    logic [15:0] rd_lin;

    assign rd_inrange = (32'(row_in_reg) < 32'(GRID_SIZE)) && (32'(col_in_reg) < 32'(GRID_SIZE));
    assign rd_lin     = 16'(row_in_reg) * 16'(GRID_SIZE) + 16'(col_in_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= LFSR_ONE;
            lfsr_reg       <= LFSR_ONE;
            gen_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            addr_reg       <= '0;
            base_reg       <= '0;
            phase_reg      <= 1'b0;
            stride2_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            addr_reg    <= addr_next;
            base_reg    <= base_next;
            phase_reg   <= phase_next;
            stride2_reg <= stride2_next;
            if (cfg_we) begin
                seed_reg <= cfg_data;
            end
            if (cmd.init_load) begin
                lfsr_reg <= (seed_reg == '0) ? LFSR_ONE : seed_reg;
            end else if (adv_we && rule.need_rand) begin
                lfsr_reg <= {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
            end
            if (cmd.init_load) begin
                gen_reg <= '0;
            end else if (cmd.gen_inc) begin
                gen_reg <= gen_reg + 16'd1;
            end
            if (cmd.iter_start) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.adv_rd_horz) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg     <= s_data.op;
            row_in_reg <= s_data.row;
            col_in_reg <= s_data.col;
        end
        if (cmd.rd_addr) begin
            rd_inrange_reg <= rd_inrange;
            rd_addr_reg    <= rd_inrange ? ADDR_W'(rd_lin) : '0;
        end
        if (cmd.adv_rd_horz) begin
            up_reg        <= up_ok ? rdata0_reg : CODE_EMPTY;
            dn_reg        <= dn_ok ? rdata1_reg : CODE_EMPTY;
            pend_addr_reg <= addr_reg;
            pend_lok_reg  <= lf_ok;
            pend_rok_reg  <= rt_ok;
        end
        if (cmd.load_result) begin
            out_reg.cell_code  <= ((op_reg == OP_READ) && rd_inrange_reg) ?
                                  rdata0_reg : CODE_EMPTY;
            out_reg.generation <= gen_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== hdl/checkerboard_tiling_automaton_top.sv =====
// Top level of the checkerboard tiling automaton: sequencer, datapath and seed port.
// A read's result passes the read address register, the memory read register and the result
// register. Initialise sweeps every cell, clear-stale every other cell, and advance every other
// cell; each recomputed cell reads both memory ports twice, vertical then horizontal.
// One item at a time. After reset (synchronous, aresetn low) a clearing pass empties the grid,
// during which no item is taken; seed writes are taken outside reset.
module checkerboard_tiling_automaton_top import cbta_pkg::*; #(
    parameter int GRID_SIZE = 81
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cbta_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output cbta_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    // The seed register can take a transfer at any time outside reset; it is only loaded
    // into the LFSR by an initialise item, so a write never disturbs an operation in flight.
    assign cfg_ready = aresetn;

    cbta_cmd_t    cmd;
    cbta_status_t status;

    // The sequencer steps the datapath through each operation. An advance runs a
    // two-phase loop over the cells of the active parity: the first phase reads the
    // cells above and below while the previous cell is written back, the second reads
    // the cells left and right. Cells of the same parity never neighbor each other,
    // so the grid is updated in place and the raster order of random draws is kept.
    cbta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    // The result register lives in the datapath, so the next item can be taken
    // while a finished result still waits for its transfer.
    cbta_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .status   (status),
        .m_data   (m_data)
    );

endmodule

// ===== hdl/cbta_sva.sv =====
// Port-level checker of the tiling automaton and its bind to the top level.
`include "checkerboard_tiling_automaton_top_macros.svh"

module cbta_sva import cbta_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input cbta_out_t m_data
);

    `CTA_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `CTA_ASSERT_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready, "second item taken during an operation")
    `CTA_ASSERT_IMPL(a_code_legal, m_valid, m_data.cell_code <= CODE_RIGHT, "illegal cell code in result")
    `CTA_ASSERT_IMPL(a_clear_after_reset, $rose(aresetn), !s_ready, "item taken before the grid was cleared")

endmodule

bind checkerboard_tiling_automaton_top cbta_sva u_sva (.*);
